// ===== design/ofx_pkg.sv =====
// shared types, codes and sizes for the offset fixup table
package ofx_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int POS_W       = 40;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int LOC_W    = 40;
  localparam int VAL_W    = 32;
  localparam int LEN_W    = 40;
  localparam int DELTA_W  = 41;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_SHIFT = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] loc;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
  } ofx_rec_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             write;
    logic             shift;
    logic             rotate;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] dpos;
    logic [VAL_W-1:0] dval;
    ofx_rec_t         rec;
  } ofx_cmd_t;

endpackage

// ===== design/ofx_if.sv =====
// request and result channel interfaces
interface ofx_in_if;
  import ofx_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic                      kind;
  logic [LOC_W-1:0]          location;
  logic [VAL_W-1:0]          value;
  logic [LOC_W-1:0]          start_req;
  logic [LEN_W-1:0]          length;
  logic signed [DELTA_W-1:0] delta;

  modport source (output valid, op, kind, location, value, start_req, length, delta,
                  input ready);
  modport sink (input valid, op, kind, location, value, start_req, length, delta,
                output ready);
endinterface

interface ofx_out_if;
  import ofx_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LOC_W-1:0]    patch_location;
  logic [VAL_W-1:0]    patch_value;
  logic                last;

  modport source (output valid, status, patch_location, patch_value, last, input ready);
  modport sink (input valid, status, patch_location, patch_value, last, output ready);
endinterface

// ===== design/ofx_cell.sv =====
// one table cell: holds a record, applies shifts, passes its record on during dumps
module ofx_cell (
  input  logic              clk,
  input  ofx_pkg::ofx_cmd_t cmd,
  input  logic              wr_en,
  input  logic              wrap,
  input  ofx_pkg::ofx_rec_t nbr_rec,
  input  ofx_pkg::ofx_rec_t head_rec,
  output ofx_pkg::ofx_rec_t rec
);
  import ofx_pkg::*;

  ofx_rec_t rec_r;
  ofx_rec_t rec_nxt;
  logic     ge_start;
  logic     le_start;
  logic     le_end;
  logic     lt_loc;
  logic     hit;

  assign ge_start = cmd.pos >= rec_r.start_pos;
  assign le_start = cmd.pos <= rec_r.start_pos;
  assign le_end   = cmd.pos <= rec_r.end_pos;
  assign lt_loc   = cmd.pos < rec_r.loc;
  assign hit      = rec_r.kind ? (ge_start && le_end) : le_start;

  always_comb begin
    rec_nxt = rec_r;
    priority if (wr_en) begin
      rec_nxt = cmd.rec;
    end else if (cmd.rotate) begin
      // last live cell closes the ring back to the head
      rec_nxt = wrap ? head_rec : nbr_rec;
    end else if (cmd.shift) begin
      if (hit) rec_nxt.val = rec_r.val + cmd.dval;
      if (lt_loc) rec_nxt.loc = rec_r.loc + cmd.dpos;
      if (le_start) rec_nxt.start_pos = rec_r.start_pos + cmd.dpos;
      if (le_end) rec_nxt.end_pos = rec_r.end_pos + cmd.dpos;
    end else begin
      rec_nxt = rec_r;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

// ===== design/ofx_ctrl.sv =====
// request decode, record count, dump sequencing and result register
module ofx_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  ofx_in_if.sink                   in_ch,
  ofx_out_if.source                out_ch,
  input  ofx_pkg::ofx_rec_t        head_rec,
  output ofx_pkg::ofx_cmd_t        cmd,
  output logic [ofx_pkg::CNT_W-1:0] count
);
  import ofx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RESP = 3'b010,
    S_DUMP = 3'b100
  } ofx_state_t;

  ofx_state_t          state_r,  state_nxt;
  logic [CNT_W-1:0]    count_r,  count_nxt;
  logic [CNT_W-1:0]    idx_r,    idx_nxt;
  logic                valid_r,  valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [LOC_W-1:0]    loc_r,    loc_nxt;
  logic [VAL_W-1:0]    val_r,    val_nxt;
  logic                last_r,   last_nxt;
  logic                acc;
  logic [POS_W-1:0]    start_p;
  logic [POS_W-1:0]    len_p;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign start_p     = POS_W'(in_ch.start_req);
  assign len_p       = POS_W'(in_ch.length);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    valid_nxt  = valid_r;
    status_nxt = status_r;
    loc_nxt    = loc_r;
    val_nxt    = val_r;
    last_nxt   = last_r;

    cmd               = '0;
    cmd.pos           = POS_W'(in_ch.location);
    cmd.dpos          = POS_W'(in_ch.delta);
    cmd.dval          = in_ch.delta[VAL_W-1:0];
    cmd.rec.kind      = in_ch.kind;
    cmd.rec.loc       = POS_W'(in_ch.location);
    cmd.rec.val       = in_ch.value;
    cmd.rec.start_pos = start_p;
    cmd.rec.end_pos   = in_ch.kind ? (start_p + len_p - POS_W'(1)) : '0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          valid_nxt  = 1'b1;
          status_nxt = ST_OK;
          loc_nxt    = '0;
          val_nxt    = '0;
          last_nxt   = 1'b1;
          state_nxt  = S_RESP;
          unique case (in_ch.op)
            OP_ADD: begin
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                cmd.write = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_SHIFT: begin
              cmd.shift = 1'b1;
            end
            OP_DUMP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                loc_nxt    = LOC_W'(head_rec.loc);
                val_nxt    = head_rec.val;
                last_nxt   = (count_r == CNT_W'(1));
                cmd.rotate = 1'b1;
                idx_nxt    = CNT_W'(1);
                state_nxt  = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        if (out_ch.ready) begin
          valid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_ch.ready) begin
          if (idx_r == count_r) begin
            valid_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            // head cell always holds the next record in insertion order
            loc_nxt    = LOC_W'(head_rec.loc);
            val_nxt    = head_rec.val;
            last_nxt   = (idx_r + CNT_W'(1) == count_r);
            cmd.rotate = 1'b1;
            idx_nxt    = idx_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    loc_r    <= loc_nxt;
    val_r    <= val_nxt;
    last_r   <= last_nxt;
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.patch_location = loc_r;
  assign out_ch.patch_value    = val_r;
  assign out_ch.last           = last_r;
  assign count                 = count_r;

endmodule

// ===== design/offset_fixup_table.sv =====
// top level: controller plus a ring of record cells
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid / ready | op, kind, location, value, start_req, length, delta
//  out_ch  | out | valid / ready | status, patch_location, patch_value, last
//
// add, shift and unknown requests each give a single result, which waits
// in the output register until taken; one request is in work at a time.
// a dump gives one result per stored record, made by rotating the live cells
// through the head cell, which feeds the output register.
// out_ch.ready low freezes the ring and the result; in_ch.ready returns after
// the final result of a request is taken.
// reset empties the table at once (the count clears); cell contents need no reset.
module offset_fixup_table (
  input  logic      clk,
  input  logic      rst_n,
  ofx_in_if.sink    in_ch,
  ofx_out_if.source out_ch
);
  import ofx_pkg::*;

  ofx_cmd_t         cmd;
  logic [CNT_W-1:0] count;
  ofx_rec_t         recs [TABLE_DEPTH];

  ofx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .head_rec (recs[0]),
    .cmd      (cmd),
    .count    (count)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ofx_rec_t nbr;
    logic     wr_en;
    logic     wrap;

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign nbr = recs[0];
    end else begin : g_mid
      assign nbr = recs[i+1];
    end

    assign wr_en = cmd.write && (count == CNT_W'(i));
    assign wrap  = (count == CNT_W'(i + 1));

    ofx_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .wr_en    (wr_en),
      .wrap     (wrap),
      .nbr_rec  (nbr),
      .head_rec (recs[0]),
      .rec      (recs[i])
    );
  end

endmodule

// ===== design/ofx_checker.sv =====
// port-level checks for the offset fixup table, bound to the top level
module ofx_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ofx_pkg::STATUS_W-1:0] out_status,
  input logic                         out_last
);
  import ofx_pkg::*;

  // one request at a time: no new request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken while a result is pending");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (out_valid && !in_ready))
    else $error("no result after request");

  // a dump keeps delivering until the last mark
  a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("result stream broken before last");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> out_last)
    else $error("error status without last mark");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind offset_fixup_table ofx_checker u_ofx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_last   (out_ch.last)
);
